>>> rtl/mrsc_pkg.sv
`default_nettype none
package mrsc_pkg;

	localparam int NUM_REGS = 32;
	localparam int REG_AW = $clog2(NUM_REGS);

	localparam logic [31:0] FILL_VALUE = 32'hDEADBEEF;
	localparam logic [31:0] RESET_PC_DEFAULT = 32'hBFC00000;
	localparam logic [31:0] SEG_MASK = 32'hF0000000;
	localparam int ISOLATE_BIT = 16;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_BCOND = 6'h01;
	localparam logic [5:0] OP_J = 6'h02;
	localparam logic [5:0] OP_JAL = 6'h03;
	localparam logic [5:0] OP_BEQ = 6'h04;
	localparam logic [5:0] OP_BNE = 6'h05;
	localparam logic [5:0] OP_BLEZ = 6'h06;
	localparam logic [5:0] OP_BGTZ = 6'h07;
	localparam logic [5:0] OP_ADDI = 6'h08;
	localparam logic [5:0] OP_ADD_IMM_U = 6'h09;
	localparam logic [5:0] OP_SLTI = 6'h0A;
	localparam logic [5:0] OP_ANDI = 6'h0C;
	localparam logic [5:0] OP_ORI = 6'h0D;
	localparam logic [5:0] OP_LUI = 6'h0F;
	localparam logic [5:0] OP_COP0 = 6'h10;
	localparam logic [5:0] OP_LB = 6'h20;
	localparam logic [5:0] OP_LW = 6'h23;
	localparam logic [5:0] OP_LBU = 6'h24;
	localparam logic [5:0] OP_SB = 6'h28;
	localparam logic [5:0] OP_SH = 6'h29;
	localparam logic [5:0] OP_SW = 6'h2B;

	// special function codes
	localparam logic [5:0] FN_SLL = 6'h00;
	localparam logic [5:0] FN_SRA = 6'h03;
	localparam logic [5:0] FN_JR = 6'h08;
	localparam logic [5:0] FN_JALR = 6'h09;
	localparam logic [5:0] FN_ADD = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND = 6'h24;
	localparam logic [5:0] FN_OR = 6'h25;
	localparam logic [5:0] FN_SLTU = 6'h2B;

	// cop0 move codes, cop0 status register and link register
	localparam logic [4:0] CP_MF = 5'd0;
	localparam logic [4:0] CP_MT = 5'd4;
	localparam logic [4:0] CP_SR = 5'd12;
	localparam logic [4:0] LINK_REG = 5'd31;

	localparam logic [2:0] MOP_NONE = 3'd0;
	localparam logic [2:0] MOP_RD_WORD = 3'd1;
	localparam logic [2:0] MOP_RD_BYTE = 3'd2;
	localparam logic [2:0] MOP_WR_WORD = 3'd3;
	localparam logic [2:0] MOP_WR_HALF = 3'd4;
	localparam logic [2:0] MOP_WR_BYTE = 3'd5;

	localparam logic [2:0] ST_DONE = 3'd0;
	localparam logic [2:0] ST_AWAIT = 3'd1;
	localparam logic [2:0] ST_BAD_OP = 3'd2;
	localparam logic [2:0] ST_OVF = 3'd3;
	localparam logic [2:0] ST_BAD_COP = 3'd4;
	localparam logic [2:0] ST_HALTED = 3'd5;

	localparam logic [1:0] LD_NONE = 2'd0;
	localparam logic [1:0] LD_WORD = 2'd1;
	localparam logic [1:0] LD_SBYTE = 2'd2;
	localparam logic [1:0] LD_UBYTE = 2'd3;

	localparam logic KIND_INSTR = 1'b0;
	localparam logic KIND_REPLY = 1'b1;

	localparam int CFG_AW = 3;
	localparam logic CFG_RESET_PC = 1'b0;

	typedef struct packed {
		logic [31:0] pc;
		logic [31:0] last_fetch;
		logic [31:0] sr;
		logic [REG_AW-1:0] pend_dest;
		logic [1:0] pend_type;
		logic halted;
	} arch_state_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic [2:0] mem_op;
		logic [31:0] mem_addr;
		logic [31:0] mem_wdata;
		logic [2:0] status;
	} result_t;

	typedef struct packed {
		logic wr_en;
		logic [REG_AW-1:0] wr_addr;
		logic [31:0] wr_data;
	} reg_write_t;

endpackage
`default_nettype wire

>>> rtl/mrsc_in_if.sv
`default_nettype none
interface mrsc_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic [31:0] instr_word;
	logic [31:0] read_data;
	modport source(output valid, kind, instr_word, read_data, input ready);
	modport sink(input valid, kind, instr_word, read_data, output ready);
endinterface
`default_nettype wire

>>> rtl/mrsc_out_if.sv
`default_nettype none
interface mrsc_out_if;
	logic valid;
	logic ready;
	logic [31:0] next_pc;
	logic [2:0] mem_op;
	logic [31:0] mem_addr;
	logic [31:0] mem_wdata;
	logic [2:0] status;
	modport source(output valid, next_pc, mem_op, mem_addr, mem_wdata, status, input ready);
	modport sink(input valid, next_pc, mem_op, mem_addr, mem_wdata, status, output ready);
endinterface
`default_nettype wire

>>> rtl/mips_r3000_subset_core_unit.sv
`default_nettype none
// channel   dir   fields                                        request
// in_ch     in    kind, instr_word, read_data                   valid & ready
// out_ch    out   next_pc, mem_op, mem_addr, mem_wdata, status  valid & ready
// apb       in    reset_pc where paddr[2] = 0                   psel & penable & pwrite
//
// one request per cycle sustained while out_ch takes results; operands are read from
// the register file at acceptance into the operand stage, and execution and writeback
// happen as the result register loads; the result register decouples the sides: a new
// request is taken while a result waits, as long as the operand stage is empty
// reset restores r0 = 0, other registers to the fill value, pc and reset_pc to default
module mips_r3000_subset_core_unit
	import mrsc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	mrsc_in_if.sink in_ch,
	mrsc_out_if.source out_ch,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [CFG_AW-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic valid_s1, kind_s1, in_acc, adv, out_free, cfg_wr;
	logic [31:0] instr_s1, rdata_s1, a, b, reset_pc_q;
	arch_state_t st_q, nst;
	result_t res, res_q;
	logic out_valid_q;
	reg_write_t wr, wr_gated;

	assign out_free = !out_valid_q || out_ch.ready;
	assign adv = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;
	assign in_acc = in_ch.valid && in_ch.ready;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_RESET_PC);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_RESET_PC) ? reset_pc_q : '0;

	always_comb begin
		wr_gated = wr;
		wr_gated.wr_en = wr.wr_en && adv;
	end

	mrsc_regfile u_rf (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(in_acc),
		.rs_addr(in_ch.instr_word[25:21]),
		.rt_addr(in_ch.instr_word[20:16]),
		.wr(wr_gated),
		.rs_data(a),
		.rt_data(b)
	);

	mrsc_exec u_exec (
		.kind(kind_s1),
		.instr(instr_s1),
		.rdata(rdata_s1),
		.a(a),
		.b(b),
		.st(st_q),
		.nst(nst),
		.res(res),
		.wr(wr)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1 <= in_ch.kind;
			instr_s1 <= in_ch.instr_word;
			rdata_s1 <= in_ch.read_data;
		end
		if (adv) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			reset_pc_q <= RESET_PC_DEFAULT;
			st_q <= '{pc: RESET_PC_DEFAULT, last_fetch: RESET_PC_DEFAULT, sr: '0,
				pend_dest: '0, pend_type: LD_NONE, halted: 1'b0};
		end else begin
			if (in_acc) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			if (adv) st_q <= nst;
			if (cfg_wr) begin
				reset_pc_q <= pwdata;
				st_q.pc <= pwdata;
				st_q.last_fetch <= pwdata;
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.next_pc = res_q.next_pc;
	assign out_ch.mem_op = res_q.mem_op;
	assign out_ch.mem_addr = res_q.mem_addr;
	assign out_ch.mem_wdata = res_q.mem_wdata;
	assign out_ch.status = res_q.status;
endmodule
`default_nettype wire

>>> rtl/mrsc_regfile.sv
`default_nettype none
module mrsc_regfile
	import mrsc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rd_en,
	input wire logic [REG_AW-1:0] rs_addr,
	input wire logic [REG_AW-1:0] rt_addr,
	input wire reg_write_t wr,
	output logic [31:0] rs_data,
	output logic [31:0] rt_data
);
	logic [31:0] mem [NUM_REGS];
	logic [NUM_REGS-1:0] written_q;
	logic [31:0] rs_raw_s1, rt_raw_s1, byp_data_s1;
	logic rs_ok_s1, rt_ok_s1, rs_byp_s1, rt_byp_s1, rs_zero_s1, rt_zero_s1;

	always_ff @(posedge clk) begin
		if (wr.wr_en) begin
			mem[wr.wr_addr] <= wr.wr_data;
		end
		if (rd_en) begin
			rs_raw_s1 <= mem[rs_addr];
			rt_raw_s1 <= mem[rt_addr];
			byp_data_s1 <= wr.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rs_ok_s1 <= 1'b0;
			rt_ok_s1 <= 1'b0;
			rs_byp_s1 <= 1'b0;
			rt_byp_s1 <= 1'b0;
			rs_zero_s1 <= 1'b1;
			rt_zero_s1 <= 1'b1;
		end else begin
			if (wr.wr_en) begin
				written_q[wr.wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rs_ok_s1 <= written_q[rs_addr];
				rt_ok_s1 <= written_q[rt_addr];
				// write landing in the same cycle as the read
				rs_byp_s1 <= wr.wr_en && (wr.wr_addr == rs_addr);
				rt_byp_s1 <= wr.wr_en && (wr.wr_addr == rt_addr);
				rs_zero_s1 <= (rs_addr == '0);
				rt_zero_s1 <= (rt_addr == '0);
			end
		end
	end

	always_comb begin
		if (rs_zero_s1) rs_data = '0;
		else if (rs_byp_s1) rs_data = byp_data_s1;
		else if (rs_ok_s1) rs_data = rs_raw_s1;
		else rs_data = FILL_VALUE;
		if (rt_zero_s1) rt_data = '0;
		else if (rt_byp_s1) rt_data = byp_data_s1;
		else if (rt_ok_s1) rt_data = rt_raw_s1;
		else rt_data = FILL_VALUE;
	end
endmodule
`default_nettype wire

>>> rtl/mrsc_exec.sv
`default_nettype none
module mrsc_exec
	import mrsc_pkg::*;
(
	input wire logic kind,
	input wire logic [31:0] instr,
	input wire logic [31:0] rdata,
	input wire logic [31:0] a,
	input wire logic [31:0] b,
	input wire arch_state_t st,
	output arch_state_t nst,
	output result_t res,
	output reg_write_t wr
);
	logic [5:0] op, fn;
	logic [4:0] rs, rt, rd, sa;
	logic [15:0] imm;
	logic [31:0] se, pc4, pc, br_tgt, j_tgt, sum_ai, sum_ab, wval, sr_new, ld_val;
	logic [2:0] err, mop;
	logic [31:0] maddr, mwd;
	logic [1:0] ptype;
	logic wrq, isol, neg, take;
	logic [4:0] wdest;

	assign op = instr[31:26];
	assign rs = instr[25:21];
	assign rt = instr[20:16];
	assign rd = instr[15:11];
	assign sa = instr[10:6];
	assign fn = instr[5:0];
	assign imm = instr[15:0];
	assign se = {{16{imm[15]}}, imm};
	assign pc4 = st.pc + 32'd4;
	assign br_tgt = pc4 + {se[29:0], 2'b00} - 32'd4;
	assign j_tgt = (pc4 & SEG_MASK) | {4'b0, instr[25:0], 2'b00};
	assign sum_ai = a + se;
	assign sum_ab = a + b;
	assign isol = st.sr[ISOLATE_BIT];
	assign neg = a[31];
	assign take = rt[0] ? !neg : neg;

	always_comb begin
		pc = pc4;
		wrq = 1'b0;
		wdest = rt;
		wval = '0;
		err = ST_DONE;
		mop = MOP_NONE;
		maddr = '0;
		mwd = '0;
		ptype = LD_NONE;
		sr_new = st.sr;
		case (op)
			OP_LUI: begin
				wrq = 1'b1;
				wval = {imm, 16'b0};
			end
			OP_ORI: begin
				wrq = 1'b1;
				wval = a | {16'b0, imm};
			end
			OP_ANDI: begin
				wrq = 1'b1;
				wval = a & {16'b0, imm};
			end
			OP_ADD_IMM_U: begin
				wrq = 1'b1;
				wval = sum_ai;
			end
			OP_ADDI: begin
				if (!a[31] && !se[31] && sum_ai[31]) err = ST_OVF;
				else begin
					wrq = 1'b1;
					wval = sum_ai;
				end
			end
			OP_SLTI: begin
				wrq = 1'b1;
				wval = {31'b0, $signed(a) < $signed(se)};
			end
			OP_J: pc = j_tgt;
			OP_JAL: begin
				wrq = 1'b1;
				wdest = LINK_REG;
				wval = pc4;
				pc = j_tgt;
			end
			OP_BEQ: if (a == b) pc = br_tgt;
			OP_BNE: if (a != b) pc = br_tgt;
			OP_BGTZ: if (a != '0 && !neg) pc = br_tgt;
			OP_BLEZ: if (a == '0 || neg) pc = br_tgt;
			OP_BCOND: begin
				// other rt codes fall through as a no-op
				if (rt[3:1] == 3'b000) begin
					if (rt[4]) begin
						wrq = 1'b1;
						wdest = LINK_REG;
						wval = pc4;
					end
					if (take) pc = br_tgt;
				end
			end
			OP_SW: if (!isol) begin
				mop = MOP_WR_WORD;
				maddr = sum_ai;
				mwd = b;
			end
			OP_SH: if (!isol) begin
				mop = MOP_WR_HALF;
				maddr = sum_ai;
				mwd = {16'b0, b[15:0]};
			end
			OP_SB: if (!isol) begin
				mop = MOP_WR_BYTE;
				maddr = sum_ai;
				mwd = {24'b0, b[7:0]};
			end
			OP_LW: if (!isol) begin
				mop = MOP_RD_WORD;
				maddr = sum_ai;
				ptype = LD_WORD;
			end
			OP_LB: begin
				mop = MOP_RD_BYTE;
				maddr = sum_ai;
				ptype = LD_SBYTE;
			end
			OP_LBU: begin
				mop = MOP_RD_BYTE;
				maddr = sum_ai;
				ptype = LD_UBYTE;
			end
			OP_COP0: begin
				if (rs == CP_MT) begin
					if (rd == CP_SR) sr_new = b;
					else if (!((rd == 5'd3 || rd == 5'd5 || rd == 5'd6 || rd == 5'd7 ||
						rd == 5'd9 || rd == 5'd11 || rd == 5'd13) && b == '0))
						err = ST_BAD_COP;
				end else if (rs == CP_MF) begin
					if (rd == CP_SR) begin
						wrq = 1'b1;
						wval = st.sr;
					end else err = ST_BAD_COP;
				end else err = ST_BAD_COP;
			end
			OP_SPECIAL: begin
				wdest = rd;
				case (fn)
					FN_SLL: begin
						wrq = 1'b1;
						wval = b << sa;
					end
					FN_SRA: begin
						wrq = 1'b1;
						wval = $unsigned($signed(b) >>> sa);
					end
					FN_OR: begin
						wrq = 1'b1;
						wval = a | b;
					end
					FN_AND: begin
						wrq = 1'b1;
						wval = a & b;
					end
					FN_ADDU: begin
						wrq = 1'b1;
						wval = sum_ab;
					end
					FN_SUBU: begin
						wrq = 1'b1;
						wval = a - b;
					end
					FN_SLTU: begin
						wrq = 1'b1;
						wval = {31'b0, a < b};
					end
					FN_ADD: begin
						if (!a[31] && !b[31] && sum_ab[31]) err = ST_OVF;
						else begin
							wrq = 1'b1;
							wval = sum_ab;
						end
					end
					FN_JR: pc = a;
					FN_JALR: begin
						wrq = 1'b1;
						wval = pc4;
						pc = a;
					end
					default: err = ST_BAD_OP;
				endcase
			end
			default: err = ST_BAD_OP;
		endcase
	end

	always_comb begin
		case (st.pend_type)
			LD_SBYTE: ld_val = {{24{rdata[7]}}, rdata[7:0]};
			LD_UBYTE: ld_val = {24'b0, rdata[7:0]};
			default: ld_val = rdata;
		endcase
	end

	always_comb begin
		nst = st;
		res = '{next_pc: st.last_fetch, mem_op: MOP_NONE, mem_addr: '0, mem_wdata: '0,
			status: ST_DONE};
		wr = '{wr_en: 1'b0, wr_addr: '0, wr_data: '0};
		if (st.halted) begin
			res.status = ST_HALTED;
		end else if (kind != KIND_INSTR) begin
			if (st.pend_type != LD_NONE) begin
				wr.wr_en = (st.pend_dest != '0);
				wr.wr_addr = st.pend_dest;
				wr.wr_data = ld_val;
				nst.pend_type = LD_NONE;
				nst.pend_dest = '0;
			end
		end else begin
			nst.pend_type = LD_NONE;
			nst.pend_dest = '0;
			if (err != ST_DONE) begin
				nst.halted = 1'b1;
				res.status = err;
			end else begin
				wr.wr_en = wrq && (wdest != '0);
				wr.wr_addr = wdest;
				wr.wr_data = wval;
				nst.sr = sr_new;
				nst.pc = pc;
				nst.last_fetch = st.pc;
				if (ptype != LD_NONE) begin
					nst.pend_type = ptype;
					nst.pend_dest = rt;
				end
				res.next_pc = st.pc;
				res.mem_op = mop;
				res.mem_addr = maddr;
				res.mem_wdata = mwd;
				res.status = (ptype != LD_NONE) ? ST_AWAIT : ST_DONE;
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/mrsc_checker.sv
`default_nettype none
module mrsc_checker
	import mrsc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [31:0] out_next_pc,
	input wire logic [2:0] out_mem_op,
	input wire logic [31:0] out_mem_addr,
	input wire logic [31:0] out_mem_wdata,
	input wire logic [2:0] out_status
);
	// a stalled result stays valid and holds its pc, memory op, address and status
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_next_pc) &&
		$stable(out_mem_op) && $stable(out_mem_addr) && $stable(out_status))
		else $error("result changed while stalled");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_mem_op == MOP_NONE |-> out_mem_addr == '0)
		else $error("address without memory request");

	a_wdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_mem_op != MOP_WR_WORD && out_mem_op != MOP_WR_HALF &&
		out_mem_op != MOP_WR_BYTE |-> out_mem_wdata == '0)
		else $error("write data without store");

	a_await_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_AWAIT |->
		out_mem_op == MOP_RD_WORD || out_mem_op == MOP_RD_BYTE)
		else $error("await status without read");

	a_error_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_DONE && out_status != ST_AWAIT |->
		out_mem_op == MOP_NONE)
		else $error("memory request on halting result");
endmodule

bind mips_r3000_subset_core_unit mrsc_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_next_pc(out_ch.next_pc),
	.out_mem_op(out_ch.mem_op),
	.out_mem_addr(out_ch.mem_addr),
	.out_mem_wdata(out_ch.mem_wdata),
	.out_status(out_ch.status)
);
`default_nettype wire

>>> verif/mips_r3000_subset_core_unit_test.sv
`default_nettype none
module mips_r3000_subset_core_unit_test;
	import mrsc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		bit kind;
		logic [31:0] word;
		logic [31:0] rdata;
	} core_req_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	mrsc_in_if in_ch();
	mrsc_out_if out_ch();

	mips_r3000_subset_core_unit dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// architectural state as the core should see it
	logic [31:0] arch_gpr [NUM_REGS];
	logic [31:0] arch_pc, arch_last, arch_sr, boot_pc;
	logic [4:0] arch_pdest;
	logic [1:0] arch_ptype;
	bit arch_halted;

	core_req_t req_q[$];
	result_t result_q[$];
	int errors = 0;
	int cycles = 0;
	bit in_calm = 0, out_calm = 0;
	int in_gap = 0, out_gap = 0;

	function automatic bit pos_ovf(logic [31:0] x, logic [31:0] y);
		logic [31:0] s;
		s = x + y;
		return !x[31] && !y[31] && s[31];
	endfunction

	function automatic bit cop_zero_only(logic [4:0] r);
		return r inside {5'd3, 5'd5, 5'd6, 5'd7, 5'd9, 5'd11, 5'd13};
	endfunction

	function automatic result_t core_step(bit kind, logic [31:0] w, logic [31:0] rdt);
		result_t r;
		logic [5:0] op, fn;
		logic [4:0] rs, rt, rd, sa, wdest;
		logic [31:0] imm, se, a, b, pc, fetch, sr_new, wval, v;
		logic [1:0] lt;
		logic [2:0] err;
		bit wr, isol, take;
		r = '0;
		r.next_pc = arch_last;
		if (arch_halted) begin
			r.status = ST_HALTED;
			return r;
		end
		if (kind == KIND_REPLY) begin
			if (arch_ptype != LD_NONE) begin
				v = rdt;
				if (arch_ptype == LD_SBYTE) v = {{24{rdt[7]}}, rdt[7:0]};
				else if (arch_ptype == LD_UBYTE) v = {24'h0, rdt[7:0]};
				if (arch_pdest != 0) arch_gpr[arch_pdest] = v;
				arch_ptype = LD_NONE;
				arch_pdest = 0;
			end
			r.status = ST_DONE;
			return r;
		end
		arch_ptype = LD_NONE;
		arch_pdest = 0;
		op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
		sa = w[10:6]; fn = w[5:0];
		imm = {16'h0, w[15:0]};
		se = {{16{w[15]}}, w[15:0]};
		a = arch_gpr[rs]; b = arch_gpr[rt];
		fetch = arch_pc;
		pc = fetch + 4;
		sr_new = arch_sr;
		isol = arch_sr[ISOLATE_BIT];
		wr = 0; wdest = 0; wval = 0; lt = LD_NONE; err = ST_DONE;
		case (op)
			OP_LUI: begin wr = 1; wdest = rt; wval = imm << 16; end
			OP_ORI: begin wr = 1; wdest = rt; wval = a | imm; end
			OP_ANDI: begin wr = 1; wdest = rt; wval = a & imm; end
			OP_ADD_IMM_U: begin wr = 1; wdest = rt; wval = a + se; end
			OP_ADDI: begin
				if (pos_ovf(a, se)) err = ST_OVF;
				else begin wr = 1; wdest = rt; wval = a + se; end
			end
			OP_SLTI: begin wr = 1; wdest = rt; wval = ($signed(a) < $signed(se)) ? 1 : 0; end
			OP_J: pc = {pc[31:28], w[25:0], 2'b00};
			OP_JAL: begin
				wr = 1; wdest = LINK_REG; wval = pc;
				pc = {pc[31:28], w[25:0], 2'b00};
			end
			OP_BEQ: if (a == b) pc = pc + (se << 2) - 4;
			OP_BNE: if (a != b) pc = pc + (se << 2) - 4;
			OP_BGTZ: if (a != 0 && !a[31]) pc = pc + (se << 2) - 4;
			OP_BLEZ: if (a == 0 || a[31]) pc = pc + (se << 2) - 4;
			OP_BCOND: begin
				if (rt inside {5'd0, 5'd1, 5'd16, 5'd17}) begin
					take = rt[0] ? !a[31] : a[31];
					if (rt[4]) begin wr = 1; wdest = LINK_REG; wval = pc; end
					if (take) pc = pc + (se << 2) - 4;
				end
			end
			OP_SW: if (!isol) begin
				r.mem_op = MOP_WR_WORD; r.mem_addr = a + se; r.mem_wdata = b;
			end
			OP_SH: if (!isol) begin
				r.mem_op = MOP_WR_HALF; r.mem_addr = a + se; r.mem_wdata = {16'h0, b[15:0]};
			end
			OP_SB: if (!isol) begin
				r.mem_op = MOP_WR_BYTE; r.mem_addr = a + se; r.mem_wdata = {24'h0, b[7:0]};
			end
			OP_LW: if (!isol) begin
				r.mem_op = MOP_RD_WORD; r.mem_addr = a + se; lt = LD_WORD;
			end
			OP_LB: begin r.mem_op = MOP_RD_BYTE; r.mem_addr = a + se; lt = LD_SBYTE; end
			OP_LBU: begin r.mem_op = MOP_RD_BYTE; r.mem_addr = a + se; lt = LD_UBYTE; end
			OP_COP0: begin
				if (rs == CP_MT) begin
					if (rd == CP_SR) sr_new = b;
					else if (!cop_zero_only(rd) || b != 0) err = ST_BAD_COP;
				end else if (rs == CP_MF) begin
					if (rd == CP_SR) begin wr = 1; wdest = rt; wval = arch_sr; end
					else err = ST_BAD_COP;
				end else err = ST_BAD_COP;
			end
			OP_SPECIAL: begin
				case (fn)
					FN_SLL: begin wr = 1; wdest = rd; wval = b << sa; end
					FN_SRA: begin wr = 1; wdest = rd; wval = $signed(b) >>> sa; end
					FN_OR: begin wr = 1; wdest = rd; wval = a | b; end
					FN_AND: begin wr = 1; wdest = rd; wval = a & b; end
					FN_ADDU: begin wr = 1; wdest = rd; wval = a + b; end
					FN_SUBU: begin wr = 1; wdest = rd; wval = a - b; end
					FN_SLTU: begin wr = 1; wdest = rd; wval = (a < b) ? 1 : 0; end
					FN_ADD: begin
						if (pos_ovf(b, a)) err = ST_OVF;
						else begin wr = 1; wdest = rd; wval = a + b; end
					end
					FN_JR: pc = a;
					FN_JALR: begin wr = 1; wdest = rd; wval = pc; pc = a; end
					default: err = ST_BAD_OP;
				endcase
			end
			default: err = ST_BAD_OP;
		endcase
		if (err != ST_DONE) begin
			arch_halted = 1;
			r = '0;
			r.next_pc = arch_last;
			r.status = err;
			return r;
		end
		if (wr && wdest != 0) arch_gpr[wdest] = wval;
		arch_sr = sr_new;
		arch_pc = pc;
		arch_last = fetch;
		if (lt != LD_NONE) begin
			arch_ptype = lt;
			arch_pdest = rt;
		end
		if (r.mem_op == MOP_NONE) r.mem_addr = 0;
		r.next_pc = fetch;
		r.status = (lt != LD_NONE) ? ST_AWAIT : ST_DONE;
		return r;
	endfunction

	function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
			logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] enc_r(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
			logic [4:0] sa, logic [5:0] fn);
		return {OP_SPECIAL, rs, rt, rd, sa, fn};
	endfunction

	function automatic logic [31:0] enc_c(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd);
		return {OP_COP0, rs, rt, rd, 11'h0};
	endfunction

	task automatic push_req(bit kind, logic [31:0] w, logic [31:0] d);
		core_req_t q;
		q.kind = kind; q.word = w; q.rdata = d;
		req_q.push_back(q);
		result_q.push_back(core_step(kind, w, d));
	endtask

	task automatic push_instr(logic [31:0] w);
		push_req(KIND_INSTR, w, $urandom);
	endtask

	task automatic push_reply(logic [31:0] d);
		push_req(KIND_REPLY, $urandom, d);
	endtask

	function automatic logic [4:0] pick_reg();
		return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
	endfunction

	function automatic logic [15:0] pick_imm();
		case ($urandom_range(0, 11))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h7FFF;
			3: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic gen_random();
		int c;
		logic [4:0] rs, rt, rd;
		logic [15:0] imm;
		logic [5:0] op, fn;
		c = $urandom_range(0, 99);
		rs = pick_reg(); rt = pick_reg(); rd = pick_reg();
		imm = pick_imm();
		if (c < 20) begin
			case ($urandom_range(0, 5))
				0: op = OP_LUI;
				1: op = OP_ORI;
				2: op = OP_ANDI;
				3: op = OP_ADD_IMM_U;
				4: op = OP_ADDI;
				default: op = OP_SLTI;
			endcase
			// keep the core running: an overflowing addi would halt it for good
			if (op == OP_ADDI && pos_ovf(arch_gpr[rs], {{16{imm[15]}}, imm})) op = OP_ADD_IMM_U;
			push_instr(enc_i(op, rs, rt, imm));
		end else if (c < 40) begin
			case ($urandom_range(0, 7))
				0: fn = FN_SLL;
				1: fn = FN_SRA;
				2: fn = FN_OR;
				3: fn = FN_AND;
				4: fn = FN_ADDU;
				5: fn = FN_ADD;
				6: fn = FN_SUBU;
				default: fn = FN_SLTU;
			endcase
			if (fn == FN_ADD && pos_ovf(arch_gpr[rt], arch_gpr[rs])) fn = FN_ADDU;
			push_instr(enc_r(rs, rt, rd, 5'($urandom), fn));
		end else if (c < 52) begin
			case ($urandom_range(0, 4))
				0: op = OP_BEQ;
				1: op = OP_BNE;
				2: op = OP_BLEZ;
				3: op = OP_BGTZ;
				default: begin
					op = OP_BCOND;
					if ($urandom_range(0, 1)) case ($urandom_range(0, 3))
						0: rt = 5'd0;
						1: rt = 5'd1;
						2: rt = 5'd16;
						default: rt = 5'd17;
					endcase
					else rt = 5'($urandom);
				end
			endcase
			push_instr(enc_i(op, rs, rt, imm));
		end else if (c < 58) begin
			case ($urandom_range(0, 3))
				0: push_instr({OP_J, 26'($urandom)});
				1: push_instr({OP_JAL, 26'($urandom)});
				2: push_instr(enc_r(rs, rt, rd, 5'($urandom), FN_JR));
				default: push_instr(enc_r(rs, rt, rd, 5'($urandom), FN_JALR));
			endcase
		end else if (c < 68) begin
			case ($urandom_range(0, 2))
				0: op = OP_SW;
				1: op = OP_SH;
				default: op = OP_SB;
			endcase
			push_instr(enc_i(op, rs, rt, imm));
		end else if (c < 82) begin
			case ($urandom_range(0, 2))
				0: op = OP_LW;
				1: op = OP_LB;
				default: op = OP_LBU;
			endcase
			push_instr(enc_i(op, rs, rt, imm));
			if ($urandom_range(0, 9) != 0) push_reply($urandom);
		end else if (c < 90) begin
			case ($urandom_range(0, 3))
				0: push_instr(enc_c(CP_MT, 5'd0, CP_SR));
				1: push_instr(enc_c(CP_MT, rt, CP_SR));
				2: push_instr(enc_c(CP_MF, rt, CP_SR));
				// zero written to a register that only takes zero
				default: push_instr(enc_c(CP_MT, 5'd0, 5'($urandom_range(0, 1) ?
					(($urandom_range(0, 3) == 0) ? 3 : $urandom_range(5, 7)) :
					9 + 2 * $urandom_range(0, 2))));
			endcase
		end else if (c < 95) begin
			push_reply($urandom);
		end else begin
			push_instr(enc_r(rs, rt, 5'd0, 5'($urandom), FN_SLL));
		end
	endtask

	function automatic bit known_op(logic [5:0] op);
		return op inside {OP_SPECIAL, OP_BCOND, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ,
			OP_BGTZ, OP_ADDI, OP_ADD_IMM_U, OP_SLTI, OP_ANDI, OP_ORI, OP_LUI, OP_COP0,
			OP_LB, OP_LW, OP_LBU, OP_SB, OP_SH, OP_SW};
	endfunction

	task automatic push_halt();
		logic [5:0] op;
		case ($urandom_range(0, 5))
			0: begin
				op = 6'($urandom);
				while (known_op(op)) op = 6'($urandom);
				push_instr({op, 26'($urandom)});
			end
			1: push_instr(enc_r(5'd1, 5'd2, 5'd3, 5'd0, 6'h1A));
			2: begin
				push_instr(enc_i(OP_LUI, 5'd0, 5'd2, 16'h7FFF));
				push_instr(enc_i(OP_ORI, 5'd2, 5'd2, 16'hFFFF));
				push_instr(enc_r(5'd2, 5'd2, 5'd3, 5'd0, FN_ADD));
			end
			3: begin
				push_instr(enc_i(OP_LUI, 5'd0, 5'd2, 16'h7FFF));
				push_instr(enc_i(OP_ORI, 5'd2, 5'd2, 16'hFFFF));
				push_instr(enc_i(OP_ADDI, 5'd2, 5'd4, 16'h0001));
			end
			4: push_instr(enc_c(5'd2, 5'd1, CP_SR));
			default: begin
				// nonzero write to a register that only takes zero
				push_instr(enc_i(OP_ORI, 5'd0, 5'd5, 16'h0001));
				push_instr(enc_c(CP_MT, 5'd5, 5'd7));
			end
		endcase
	endtask

	task automatic wait_idle();
		while (req_q.size() != 0 || result_q.size() != 0 || in_ch.valid) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [31:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= CFG_AW'(CFG_RESET_PC); pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		pwrite <= 0; penable <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		if (prdata !== v) begin
			errors++;
			if (errors <= 10) $display("reset_pc readback: exp %h got %h", v, prdata);
		end
		psel <= 0; penable <= 0;
		boot_pc = v;
		arch_pc = v;
		arch_last = v;
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("mips_r3000_subset_core_unit test failed");
			$finish;
		end
	end

	// request driver
	always @(posedge clk) begin
		core_req_t q;
		if (arst_n && (!in_ch.valid || in_ch.ready)) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_ch.valid <= 0;
			end else if (req_q.size() != 0) begin
				q = req_q.pop_front();
				in_ch.valid <= 1;
				in_ch.kind <= q.kind;
				in_ch.instr_word <= q.word;
				in_ch.read_data <= q.rdata;
				in_gap <= in_calm ? 0 : gap_len();
			end else begin
				in_ch.valid <= 0;
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.next_pc = out_ch.next_pc;
				got.mem_op = out_ch.mem_op;
				got.mem_addr = out_ch.mem_addr;
				got.mem_wdata = out_ch.mem_wdata;
				got.status = out_ch.status;
				if (result_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result: pc %h st %0d",
						got.next_pc, got.status);
				end else begin
					want = result_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) $display(
							"mismatch: exp pc %h op %0d addr %h wd %h st %0d, got pc %h op %0d addr %h wd %h st %0d",
							want.next_pc, want.mem_op, want.mem_addr, want.mem_wdata, want.status,
							got.next_pc, got.mem_op, got.mem_addr, got.mem_wdata, got.status);
					end
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ch.ready <= 0;
			end else begin
				out_ch.ready <= 1;
				out_gap <= out_calm ? 0 : gap_len();
			end
		end
	end

	initial begin
		logic [31:0] pc_set [6];
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		in_ch.valid = 0; in_ch.kind = KIND_INSTR; in_ch.instr_word = '0; in_ch.read_data = '0;
		out_ch.ready = 0;
		boot_pc = RESET_PC_DEFAULT;
		arch_gpr[0] = 0;
		for (int k = 1; k < NUM_REGS; k++) arch_gpr[k] = FILL_VALUE;
		arch_pc = boot_pc; arch_last = boot_pc; arch_sr = 0;
		arch_pdest = 0; arch_ptype = LD_NONE; arch_halted = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// directed part: slot nop, shifts, r0, stores, loads, branches, links, cop0
		push_instr(32'h0);
		push_instr(enc_i(OP_LUI, 5'd0, 5'd1, 16'h8000));
		push_instr(enc_i(OP_ORI, 5'd1, 5'd1, 16'h00FF));
		push_instr(enc_r(5'd0, 5'd1, 5'd2, 5'd31, FN_SLL));
		push_instr(enc_r(5'd0, 5'd1, 5'd3, 5'd31, FN_SRA));
		push_instr(enc_i(OP_ADD_IMM_U, 5'd1, 5'd0, 16'h0005));
		push_instr(enc_i(OP_SW, 5'd0, 5'd1, 16'h8000));
		push_instr(enc_i(OP_SH, 5'd1, 5'd1, 16'h7FFF));
		push_instr(enc_i(OP_SB, 5'd1, 5'd1, 16'hFFFF));
		push_instr(enc_i(OP_LB, 5'd0, 5'd5, 16'h0010));
		push_reply(32'h1234_5680);
		push_instr(enc_i(OP_LBU, 5'd0, 5'd6, 16'h0011));
		push_reply(32'hFFFF_FFFF);
		push_reply(32'hA5A5_A5A5);
		push_instr(enc_i(OP_LW, 5'd1, 5'd7, 16'h0000));
		push_instr(enc_i(OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
		push_instr(enc_i(OP_BCOND, 5'd1, 5'd16, 16'h0004));
		push_instr(enc_i(OP_BCOND, 5'd1, 5'd17, 16'h0004));
		push_instr(enc_i(OP_BCOND, 5'd1, 5'd5, 16'h0004));
		push_instr({OP_JAL, 26'h3FFFFFF});
		push_instr(enc_r(5'd1, 5'd0, 5'd9, 5'd0, FN_JALR));
		push_instr(enc_c(CP_MT, 5'd0, 5'd3));
		push_instr(enc_i(OP_LUI, 5'd0, 5'd10, 16'h0001));
		push_instr(enc_c(CP_MT, 5'd10, CP_SR));
		push_instr(enc_i(OP_SW, 5'd0, 5'd1, 16'h0000));
		push_instr(enc_i(OP_LW, 5'd0, 5'd1, 16'h0000));
		push_instr(enc_i(OP_LB, 5'd0, 5'd11, 16'h0000));
		push_reply(32'h0000_007F);
		push_instr(enc_c(CP_MF, 5'd12, CP_SR));
		push_instr(enc_c(CP_MT, 5'd0, CP_SR));
		wait_idle();

		pc_set[0] = 32'h0000_0000;
		pc_set[1] = 32'hFFFF_FFFC;
		pc_set[2] = 32'hFFFF_FFFF;
		pc_set[3] = $urandom;
		pc_set[4] = 32'h8000_0000;
		pc_set[5] = $urandom & 32'hFFFF_FFFC;
		for (int ph = 0; ph < 6; ph++) begin
			cfg_write(pc_set[ph]);
			in_calm = (ph == 2);
			out_calm = (ph == 4);
			for (int n = 0; n < 210; n++) gen_random();
			wait_idle();
		end
		in_calm = 0;
		out_calm = 0;
		push_halt();
		for (int n = 0; n < 12; n++) gen_random();
		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0 && result_q.size() == 0) begin
			$display("mips_r3000_subset_core_unit test passed");
		end else begin
			$display("mips_r3000_subset_core_unit test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
